// ===== src/qsa_pkg.sv =====
// Shared constants, types and fixed-point helpers for the quaternion blend pipeline.
package qsa_pkg;

	// Component width (Q2.(COMP_W-2)) and the stream packing derived from it
	localparam int COMP_W      = 16;
	localparam int BLEND_W     = 16;
	localparam int IN_BITS     = 8 * COMP_W + BLEND_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = 4 * COMP_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Q.28 working values
	localparam int VAL_W = 34;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic [3:0][COMP_W-1:0] quat_t;

	localparam val_t Q28_ONE  = val_t'(64'sd268435456);
	localparam val_t Q28_HALF = val_t'(64'sd134217728);
	localparam logic [BLEND_W-1:0] BLEND_MAX = BLEND_W'(32768);
	localparam int T_SH = 13;

	// Polynomial coefficients in Q.28
	localparam val_t C0 = val_t'(64'sd292702021);
	localparam val_t C1 = val_t'(-64'sd871126742);
	localparam val_t C2 = val_t'(64'sd954677277);
	localparam val_t C3 = val_t'(64'sd385255882);
	localparam val_t C4 = val_t'(64'sd227636756);
	localparam val_t C5 = val_t'(-64'sd284597955);
	localparam val_t C6 = val_t'(64'sd57884885);

	// Dot product term: comp*comp scaled to Q.28
	localparam int DOT_SH   = 2 * COMP_W - 32;
	localparam int DOT_RSH  = (DOT_SH > 0) ? DOT_SH : 0;
	localparam int DOT_LSH  = (DOT_SH < 0) ? -DOT_SH : 0;
	localparam longint DOT_HALF = (DOT_RSH > 0) ? (64'sd1 <<< (DOT_RSH - 1)) : 64'sd0;

	// Blend stage: ot (Q.28) times component, result in Q.30
	localparam int A_SH  = 32 - COMP_W;
	localparam int OT_SH = COMP_W - 4;

	// Length and normalization widths
	localparam int VS_W   = 30;
	localparam int MAG_W  = 29;
	localparam int MS_W   = 60;
	localparam int ROOT_W = 30;
	localparam int QUO_W  = 31;
	localparam int NUM_W  = 60;
	localparam int FRAC_SH = 30;

	// Output rounding from Q2.30 down to the component width
	localparam int ST_SH = 32 - COMP_W;
	localparam longint ST_HALF = (ST_SH > 0) ? (64'sd1 <<< (ST_SH - 1)) : 64'sd0;
	localparam logic [COMP_W-1:0] ONE_OUT = COMP_W'(64'sd1 <<< (COMP_W - 2));

	// Payload into the square root pipeline
	typedef struct packed {
		logic [MS_W-1:0]            ms;
		logic [3:0]                 neg;
		logic [3:0][MAG_W-1:0]      m;
	} sqp_t;

	// Payload into the divider pipeline
	typedef struct packed {
		logic [ROOT_W-1:0]          mag;
		logic [3:0]                 neg;
		logic [3:0][MAG_W-1:0]      m;
	} dvp_t;

	// Divider result
	typedef struct packed {
		logic [3:0][QUO_W-1:0]      q;
		logic [3:0]                 neg;
		logic                       zero;
	} res_t;

	function automatic val_t mul28(input val_t x, input val_t y);
		logic signed [2*VAL_W-1:0] p;
		p = (2*VAL_W)'(x) * (2*VAL_W)'(y);
		p = p + ((2*VAL_W)'(64'sd1) <<< 27);
		return VAL_W'(p >>> 28);
	endfunction

	function automatic val_t dot_term(input logic signed [2*COMP_W-1:0] p);
		logic signed [65:0] e;
		e = 66'(p);
		e = (e + 66'(DOT_HALF)) >>> DOT_RSH;
		e = e <<< DOT_LSH;
		return VAL_W'(e);
	endfunction

	function automatic val_t mul_ot(input val_t x, input comp_t c);
		logic signed [VAL_W+COMP_W-1:0] p;
		p = (VAL_W+COMP_W)'(x) * (VAL_W+COMP_W)'(c);
		p = p + ((VAL_W+COMP_W)'(64'sd1) <<< (OT_SH - 1));
		return VAL_W'(p >>> OT_SH);
	endfunction

endpackage

// ===== src/quaternion_slerp_approx_unit.sv =====
// Throughput: one transaction per cycle unless the master side stalls; 11 arithmetic stages,
// 15 square root stages, 16 divider stages and the output register, all advancing together.
// A stall on the master side holds every stage; s_tready follows the output register.
// Reset (arst_n low) clears all valid bits at once; payload registers are not reset.
// Top level: stream ports, output rounding, identity on zero length.
module quaternion_slerp_approx_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend
	input  logic [qsa_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// q_x, q_y, q_z, q_w
	output logic [qsa_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// degenerate
	output logic                               m_tuser
);

	logic           en;
	qsa_pkg::quat_t in_a, in_b;
	logic           fr_valid, sq_valid, dv_valid;
	qsa_pkg::sqp_t  fr_pay;
	qsa_pkg::dvp_t  sq_pay;
	qsa_pkg::res_t  dv_res;
	logic [qsa_pkg::OUT_TDATA_W-1:0] out_word;

	// Whole pipeline advances when the output register is free or being taken
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			in_a[i] = s_tdata[i*qsa_pkg::COMP_W +: qsa_pkg::COMP_W];
			in_b[i] = s_tdata[(4+i)*qsa_pkg::COMP_W +: qsa_pkg::COMP_W];
		end
	end

	qsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_a      (in_a),
		.in_b      (in_b),
		.in_blend  (s_tdata[8*qsa_pkg::COMP_W +: qsa_pkg::BLEND_W]),
		.out_valid (fr_valid),
		.out_pay   (fr_pay)
	);

	qsa_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_pay    (fr_pay),
		.out_valid (sq_valid),
		.out_pay   (sq_pay)
	);

	qsa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_pay    (sq_pay),
		.out_valid (dv_valid),
		.out_res   (dv_res)
	);

	// Apply sign, round to component width, or substitute identity
	always_comb begin
		logic signed [qsa_pkg::QUO_W+1:0] qs;
		logic signed [qsa_pkg::QUO_W+1:0] r;
		out_word = '0;
		for (int i = 0; i < 4; i++) begin
			qs = (qsa_pkg::QUO_W+2)'(dv_res.q[i]);
			if (dv_res.neg[i]) begin
				qs = -qs;
			end
			r = (qs + (qsa_pkg::QUO_W+2)'(qsa_pkg::ST_HALF)) >>> qsa_pkg::ST_SH;
			out_word[i*qsa_pkg::COMP_W +: qsa_pkg::COMP_W] = r[qsa_pkg::COMP_W-1:0];
		end
		if (dv_res.zero) begin
			out_word = '0;
			out_word[3*qsa_pkg::COMP_W +: qsa_pkg::COMP_W] = qsa_pkg::ONE_OUT;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= out_word;
			m_tuser <= dv_res.zero;
		end
	end

endmodule

// ===== src/qsa_front.sv =====
// Front pipeline: dot product, polynomials, blend weights, weighted sum and squared length.
module qsa_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  qsa_pkg::quat_t       in_a,
	input  qsa_pkg::quat_t       in_b,
	input  logic [qsa_pkg::BLEND_W-1:0] in_blend,
	output logic                 out_valid,
	output qsa_pkg::sqp_t        out_pay
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	qsa_pkg::quat_t a_s1, a_s2, a_s3, a_s4, a_s5, a_s6, a_s7, a_s8;
	qsa_pkg::quat_t b_s1, b_s2, b_s3, b_s4, b_s5, b_s6, b_s7;
	logic signed [2*qsa_pkg::COMP_W-1:0] pd_s1 [4];
	qsa_pkg::val_t t_s1, t_s2, t_s3, t_s4, t_s5, t_s6, t_s7;
	qsa_pkg::val_t d_s2, d_s3, d_s4;
	logic neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	qsa_pkg::val_t s_s2, s_s3, s_s4, s_s5;
	qsa_pkg::val_t u_s2;
	qsa_pkg::val_t w_s3, w_s4, w_s5, w_s6;
	qsa_pkg::val_t m1_s3, n1_s3, m2_s4, n2_s4, m3_s5, pb_s5, pb_s6, p1_s6, p2_s7;
	qsa_pkg::val_t ma_s8 [4];
	qsa_pkg::val_t mb_s8 [4];
	logic signed [qsa_pkg::VS_W-1:0] vs_s9 [4];
	logic [qsa_pkg::MS_W-1:0] sq_s10 [4];
	logic [3:0] neg_s10, neg_s11;
	logic [3:0][qsa_pkg::MAG_W-1:0] m_s10, m_s11;
	logic [qsa_pkg::MS_W-1:0] ms_s11;

	// Combinational terms between stages
	logic [qsa_pkg::BLEND_W-1:0] blend_sat;
	qsa_pkg::val_t t_in, th, tm, dot, dabs, ot, otb;
	logic signed [35:0] v [4];
	logic signed [35:0] vr [4];
	logic signed [2*qsa_pkg::VS_W-1:0] sqx [4];

	assign blend_sat = (in_blend > qsa_pkg::BLEND_MAX) ? qsa_pkg::BLEND_MAX : in_blend;
	assign t_in = $signed(qsa_pkg::VAL_W'(blend_sat) << qsa_pkg::T_SH);
	assign th = t_s1 - qsa_pkg::Q28_HALF;
	assign tm = t_s1 - qsa_pkg::Q28_ONE;

	// Dot product sum and its magnitude, saturated to one
	always_comb begin
		dot = qsa_pkg::dot_term(pd_s1[0]) + qsa_pkg::dot_term(pd_s1[1])
		    + qsa_pkg::dot_term(pd_s1[2]) + qsa_pkg::dot_term(pd_s1[3]);
		dabs = dot[qsa_pkg::VAL_W-1] ? -dot : dot;
		if (dabs > qsa_pkg::Q28_ONE) begin
			dabs = qsa_pkg::Q28_ONE;
		end
	end

	// Blend weight and its signed twin
	assign ot  = t_s7 + p2_s7;
	assign otb = neg_s7 ? -ot : ot;

	// Weighted sum, rounded down to Q.26, and squares
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			v[i] = (36'($signed(a_s8[i])) <<< qsa_pkg::A_SH) - 36'(ma_s8[i]) + 36'(mb_s8[i]);
			vr[i] = (v[i] + 36'sd8) >>> 4;
			sqx[i] = (2*qsa_pkg::VS_W)'(vs_s9[i]) * (2*qsa_pkg::VS_W)'(vs_s9[i]);
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
			v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0;
			v_s9 <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
			v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6; v_s8 <= v_s7;
			v_s9 <= v_s8; v_s10 <= v_s9; v_s11 <= v_s10;
		end
	end

	// Payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// s1: capture, component products
			a_s1 <= in_a;
			b_s1 <= in_b;
			t_s1 <= t_in;
			for (int i = 0; i < 4; i++) begin
				pd_s1[i] <= $signed(in_a[i]) * $signed(in_b[i]);
			end
			// s2: dot magnitude, (t-0.5)^2, (t-0.5)(t-1)
			a_s2 <= a_s1; b_s2 <= b_s1; t_s2 <= t_s1;
			d_s2 <= dabs;
			neg_s2 <= dot[qsa_pkg::VAL_W-1];
			s_s2 <= qsa_pkg::mul28(th, th);
			u_s2 <= qsa_pkg::mul28(th, tm);
			// s3: innermost polynomial terms, t*(t-0.5)*(t-1)
			a_s3 <= a_s2; b_s3 <= b_s2; t_s3 <= t_s2; d_s3 <= d_s2;
			neg_s3 <= neg_s2; s_s3 <= s_s2;
			m1_s3 <= qsa_pkg::mul28(d_s2, qsa_pkg::C3);
			n1_s3 <= qsa_pkg::mul28(d_s2, qsa_pkg::C6);
			w_s3 <= qsa_pkg::mul28(t_s2, u_s2);
			// s4
			a_s4 <= a_s3; b_s4 <= b_s3; t_s4 <= t_s3; d_s4 <= d_s3;
			neg_s4 <= neg_s3; s_s4 <= s_s3; w_s4 <= w_s3;
			m2_s4 <= qsa_pkg::mul28(d_s3, qsa_pkg::C2 - m1_s3);
			n2_s4 <= qsa_pkg::mul28(d_s3, qsa_pkg::C5 + n1_s3);
			// s5: cubic done but for the constant, quadratic done
			a_s5 <= a_s4; b_s5 <= b_s4; t_s5 <= t_s4;
			neg_s5 <= neg_s4; s_s5 <= s_s4; w_s5 <= w_s4;
			m3_s5 <= qsa_pkg::mul28(d_s4, qsa_pkg::C1 + m2_s4);
			pb_s5 <= qsa_pkg::C4 + n2_s4;
			// s6: A*(t-0.5)^2
			a_s6 <= a_s5; b_s6 <= b_s5; t_s6 <= t_s5;
			neg_s6 <= neg_s5; w_s6 <= w_s5; pb_s6 <= pb_s5;
			p1_s6 <= qsa_pkg::mul28(qsa_pkg::C0 + m3_s5, s_s5);
			// s7: correction term for ot
			a_s7 <= a_s6; b_s7 <= b_s6; t_s7 <= t_s6; neg_s7 <= neg_s6;
			p2_s7 <= qsa_pkg::mul28(w_s6, p1_s6 + pb_s6);
			// s8: ot*a and sign(dot)*ot*b
			a_s8 <= a_s7;
			for (int i = 0; i < 4; i++) begin
				ma_s8[i] <= qsa_pkg::mul_ot(ot, $signed(a_s7[i]));
				mb_s8[i] <= qsa_pkg::mul_ot(otb, $signed(b_s7[i]));
			end
			// s9: blended vector in Q.26
			for (int i = 0; i < 4; i++) begin
				vs_s9[i] <= qsa_pkg::VS_W'(vr[i]);
			end
			// s10: squares, magnitudes and signs
			for (int i = 0; i < 4; i++) begin
				sq_s10[i] <= qsa_pkg::MS_W'(sqx[i]);
				neg_s10[i] <= vs_s9[i][qsa_pkg::VS_W-1];
				m_s10[i] <= qsa_pkg::MAG_W'(vs_s9[i][qsa_pkg::VS_W-1] ? -vs_s9[i] : vs_s9[i]);
			end
			// s11: squared length
			ms_s11 <= sq_s10[0] + sq_s10[1] + sq_s10[2] + sq_s10[3];
			neg_s11 <= neg_s10;
			m_s11 <= m_s10;
		end
	end

	assign out_valid   = v_s11;
	assign out_pay.ms  = ms_s11;
	assign out_pay.neg = neg_s11;
	assign out_pay.m   = m_s11;

endmodule

// ===== src/qsa_sqrt.sv =====
// Pipelined digit-by-digit integer square root of the squared length, two result bits a stage.
module qsa_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  qsa_pkg::sqp_t    in_pay,
	output logic             out_valid,
	output qsa_pkg::dvp_t    out_pay
);

	localparam int STEPS = 2;
	localparam int NST   = (qsa_pkg::ROOT_W + STEPS - 1) / STEPS;
	localparam int REM_W = qsa_pkg::ROOT_W + 3;

	// Stage registers, indexed by stage
	logic [NST-1:0]                v_s;
	logic [REM_W-1:0]              rem_s  [NST];
	logic [qsa_pkg::ROOT_W-1:0]    root_s [NST];
	logic [qsa_pkg::MS_W-1:0]      x_s    [NST];
	logic [3:0]                    neg_s  [NST];
	logic [3:0][qsa_pkg::MAG_W-1:0] m_s   [NST];

	// Stage inputs
	logic [REM_W-1:0]              src_rem  [NST];
	logic [qsa_pkg::ROOT_W-1:0]    src_root [NST];
	logic [qsa_pkg::MS_W-1:0]      src_x    [NST];
	logic [REM_W-1:0]              nx_rem   [NST];
	logic [qsa_pkg::ROOT_W-1:0]    nx_root  [NST];
	logic [qsa_pkg::MS_W-1:0]      nx_x     [NST];

	always_comb begin
		src_rem[0]  = '0;
		src_root[0] = '0;
		src_x[0]    = in_pay.ms;
		for (int g = 1; g < NST; g++) begin
			src_rem[g]  = rem_s[g-1];
			src_root[g] = root_s[g-1];
			src_x[g]    = x_s[g-1];
		end
	end

	// Two restoring square root steps per stage
	always_comb begin
		logic [REM_W-1:0]           rm;
		logic [qsa_pkg::ROOT_W-1:0] rt;
		logic [qsa_pkg::MS_W-1:0]   xs;
		logic [REM_W-1:0]           tr;
		for (int g = 0; g < NST; g++) begin
			rm = src_rem[g];
			rt = src_root[g];
			xs = src_x[g];
			for (int k = 0; k < STEPS; k++) begin
				if (g * STEPS + k < qsa_pkg::ROOT_W) begin
					rm = {rm[REM_W-3:0], xs[qsa_pkg::MS_W-1 -: 2]};
					xs = xs << 2;
					tr = REM_W'({rt, 2'b01});
					if (rm >= tr) begin
						rm = rm - tr;
						rt = {rt[qsa_pkg::ROOT_W-2:0], 1'b1};
					end else begin
						rt = {rt[qsa_pkg::ROOT_W-2:0], 1'b0};
					end
				end
			end
			nx_rem[g]  = rm;
			nx_root[g] = rt;
			nx_x[g]    = xs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NST; g++) begin
				rem_s[g]  <= nx_rem[g];
				root_s[g] <= nx_root[g];
				x_s[g]    <= nx_x[g];
			end
			neg_s[0] <= in_pay.neg;
			m_s[0]   <= in_pay.m;
			for (int g = 1; g < NST; g++) begin
				neg_s[g] <= neg_s[g-1];
				m_s[g]   <= m_s[g-1];
			end
		end
	end

	assign out_valid   = v_s[NST-1];
	assign out_pay.mag = root_s[NST-1];
	assign out_pay.neg = neg_s[NST-1];
	assign out_pay.m   = m_s[NST-1];

endmodule

// ===== src/qsa_div.sv =====
// Pipelined four-lane restoring divider: rounded |v_i| * 2^30 / magnitude.
module qsa_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  qsa_pkg::dvp_t    in_pay,
	output logic             out_valid,
	output qsa_pkg::res_t    out_res
);

	localparam int STEPS = 2;
	localparam int NST   = (qsa_pkg::QUO_W + STEPS - 1) / STEPS;
	localparam int REM_W = qsa_pkg::ROOT_W + 2;
	localparam int LO_W  = qsa_pkg::QUO_W;

	logic [NST-1:0]               v_s;
	logic [3:0][REM_W-1:0]        rem_s [NST];
	logic [3:0][LO_W-1:0]         lo_s  [NST];
	logic [3:0][qsa_pkg::QUO_W-1:0] q_s [NST];
	logic [qsa_pkg::ROOT_W-1:0]   mag_s [NST];
	logic [3:0]                   neg_s [NST];

	logic [3:0][REM_W-1:0]        src_rem [NST];
	logic [3:0][LO_W-1:0]         src_lo  [NST];
	logic [3:0][qsa_pkg::QUO_W-1:0] src_q [NST];
	logic [qsa_pkg::ROOT_W-1:0]   src_mag [NST];
	logic [3:0][REM_W-1:0]        nx_rem  [NST];
	logic [3:0][LO_W-1:0]         nx_lo   [NST];
	logic [3:0][qsa_pkg::QUO_W-1:0] nx_q  [NST];

	// Numerator with half the divisor added for rounding
	always_comb begin
		logic [qsa_pkg::NUM_W-1:0] num;
		for (int i = 0; i < 4; i++) begin
			num = (qsa_pkg::NUM_W'(in_pay.m[i]) << qsa_pkg::FRAC_SH)
			    + qsa_pkg::NUM_W'(in_pay.mag >> 1);
			src_rem[0][i] = REM_W'(num >> LO_W);
			src_lo[0][i]  = num[LO_W-1:0];
			src_q[0][i]   = '0;
		end
		src_mag[0] = in_pay.mag;
		for (int g = 1; g < NST; g++) begin
			src_rem[g] = rem_s[g-1];
			src_lo[g]  = lo_s[g-1];
			src_q[g]   = q_s[g-1];
			src_mag[g] = mag_s[g-1];
		end
	end

	// Two quotient bits per stage on each lane
	always_comb begin
		logic [REM_W-1:0]          rm;
		logic [LO_W-1:0]           lo;
		logic [qsa_pkg::QUO_W-1:0] qq;
		for (int g = 0; g < NST; g++) begin
			for (int i = 0; i < 4; i++) begin
				rm = src_rem[g][i];
				lo = src_lo[g][i];
				qq = src_q[g][i];
				for (int k = 0; k < STEPS; k++) begin
					if (g * STEPS + k < qsa_pkg::QUO_W) begin
						rm = {rm[REM_W-2:0], lo[LO_W-1]};
						lo = lo << 1;
						if (rm >= REM_W'(src_mag[g])) begin
							rm = rm - REM_W'(src_mag[g]);
							qq = {qq[qsa_pkg::QUO_W-2:0], 1'b1};
						end else begin
							qq = {qq[qsa_pkg::QUO_W-2:0], 1'b0};
						end
					end
				end
				nx_rem[g][i] = rm;
				nx_lo[g][i]  = lo;
				nx_q[g][i]   = qq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[NST-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NST; g++) begin
				rem_s[g] <= nx_rem[g];
				lo_s[g]  <= nx_lo[g];
				q_s[g]   <= nx_q[g];
				mag_s[g] <= src_mag[g];
			end
			neg_s[0] <= in_pay.neg;
			for (int g = 1; g < NST; g++) begin
				neg_s[g] <= neg_s[g-1];
			end
		end
	end

	assign out_valid    = v_s[NST-1];
	assign out_res.q    = q_s[NST-1];
	assign out_res.neg  = neg_s[NST-1];
	assign out_res.zero = (mag_s[NST-1] == '0);

endmodule

// ===== src/qsa_checker.sv =====
// Port-level checks for the quaternion blend unit, bound to the top level.
module qsa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [qsa_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tuser
);

	// Nothing shows on the master side while in reset
	a_rst_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("m_tvalid high during reset");

	// A stalled result holds its transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// Input side is open exactly when the output register can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow output register");

	// Degenerate results carry the identity quaternion
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |->
		(m_tdata[3*qsa_pkg::COMP_W +: qsa_pkg::COMP_W] == qsa_pkg::ONE_OUT) &&
		(m_tdata[3*qsa_pkg::COMP_W-1:0] == '0))
		else $error("degenerate result is not identity");

endmodule

bind quaternion_slerp_approx_unit qsa_checker u_qsa_checker (.*);
